@@ src/tgql_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and helpers of the glyph quad layout block
package tgql_pkg;

   localparam int POS_W          = 20;
   localparam int ENTRY_COORD_W  = 12;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 8;

   // item and result kinds
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_CHAR   = 1'b1;
   localparam logic RES_CORNER  = 1'b0;
   localparam logic RES_MEAS    = 1'b1;

   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_SPACE   = 8'd32;

   localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_LOG2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDING     = 3'd4;

   localparam logic [7:0] RST_MIN_CODE    = 8'd32;
   localparam logic [7:0] RST_MAX_CODE    = 8'd126;
   localparam logic [7:0] RST_LINE_HEIGHT = 8'd16;
   localparam logic [3:0] RST_ATLAS_LOG2  = 4'd8;
   localparam logic       RST_WINDING     = 1'b0;

   // output sequencer beats
   localparam logic [2:0] BEAT_FIRST_CORNER = 3'd0;
   localparam logic [2:0] BEAT_LAST_CORNER  = 3'd3;
   localparam logic [2:0] BEAT_MEAS         = 3'd4;

   // one glyph's worth of positions plus the measurement snapshot
   typedef struct packed {
      logic                    quad;
      logic                    meas;
      logic                    fin;
      logic                    cw;
      logic signed [POS_W-1:0] x0;
      logic signed [POS_W-1:0] y0;
      logic signed [POS_W-1:0] x1;
      logic signed [POS_W-1:0] y1;
      logic signed [POS_W-1:0] lw;
      logic signed [POS_W-1:0] wl;
      logic signed [POS_W-1:0] nt;
   } tgql_job_type;

   // add a non-negative byte and clamp at the top of the position range
   function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                       input logic [7:0] b);
      logic signed [POS_W:0] s;
      s = {a[POS_W-1], a} + {{(POS_W-7){1'b0}}, b};
      sat_add = (s[POS_W:POS_W-1] == 2'b01) ? POS_MAX : s[POS_W-1:0];
   endfunction

endpackage

@@ src/tgql_if.sv @@
`timescale 1ns / 1ps
// request and response channel interfaces of the glyph quad layout block
interface tgql_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [7:0]         entry_index;
   logic [11:0]        entry_atlas_x;
   logic [11:0]        entry_atlas_y;
   logic [7:0]         entry_cell_size;
   logic [7:0]         entry_advance;
   logic [7:0]         char_code;
   logic               first_of_string;
   logic               last_of_string;
   logic signed [15:0] start_x;
   logic signed [15:0] start_y;

   modport source (
      output valid, kind, entry_index, entry_atlas_x, entry_atlas_y, entry_cell_size,
             entry_advance, char_code, first_of_string, last_of_string, start_x, start_y,
      input  ready
   );
   modport sink (
      input  valid, kind, entry_index, entry_atlas_x, entry_atlas_y, entry_cell_size,
             entry_advance, char_code, first_of_string, last_of_string, start_x, start_y,
      output ready
   );
endinterface

interface tgql_rsp_if #(
   parameter int TEX_W = 17
);
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic signed [19:0] pos_x;
   logic signed [19:0] pos_y;
   logic [TEX_W-1:0]   tex_s;
   logic [TEX_W-1:0]   tex_t;
   logic [1:0]         corner;
   logic               last;

   modport source (
      output valid, result_kind, pos_x, pos_y, tex_s, tex_t, corner, last,
      input  ready
   );
   modport sink (
      input  valid, result_kind, pos_x, pos_y, tex_s, tex_t, corner, last,
      output ready
   );
endinterface

@@ src/tgql_emit.sv @@
`timescale 1ns / 1ps
// quad corner and measurement sequencer with registered response output
module tgql_emit import tgql_pkg::*; #(
   parameter int TEXEL_W       = 13,
   parameter int TEX_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               hand_valid,
   output logic               hand_ready,
   input  tgql_job_type       job,
   input  logic [TEXEL_W-1:0] tex_sa,
   input  logic [TEXEL_W-1:0] tex_sb,
   input  logic [TEXEL_W-1:0] tex_ta,
   input  logic [TEXEL_W-1:0] tex_tb,
   input  logic [7:0]         line_height,
   input  logic [3:0]         atlas_log2,
   tgql_rsp_if.source         rsp_chan
);

   localparam int TEX_W = TEX_FRAC_BITS + 1;
   localparam int SW    = TEXEL_W + TEX_FRAC_BITS + 16;
   localparam logic [SW-1:0] TEX_ONE = SW'(1) << TEX_FRAC_BITS;

   // texel to normalized coordinate, round half up, clamp at 1.0
   function automatic logic [TEX_W-1:0] tex_coord(input logic [TEXEL_W-1:0] texel,
                                                  input logic [3:0] shift);
      logic [SW-1:0] scaled;
      logic [SW-1:0] half;
      logic [SW-1:0] quot;
      scaled = SW'(texel) << TEX_FRAC_BITS;
      half   = (SW'(1) << shift) >> 1;
      quot   = (scaled + half) >> shift;
      tex_coord = (quot > TEX_ONE) ? TEX_ONE[TEX_W-1:0] : quot[TEX_W-1:0];
   endfunction

   tgql_job_type       job_ff;
   logic [TEXEL_W-1:0] sa_ff, sb_ff, ta_ff, tb_ff;
   logic               job_valid_ff, job_valid_in;
   logic [2:0]         beat_ff, beat_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic signed [POS_W-1:0] rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [POS_W-1:0] rsp_pos_y_ff, rsp_pos_y_in;
   logic [TEX_W-1:0]        rsp_tex_s_ff, rsp_tex_s_in;
   logic [TEX_W-1:0]        rsp_tex_t_ff, rsp_tex_t_in;
   logic [1:0]              rsp_corner_ff, rsp_corner_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    out_load, last_beat, done_now, take, emit;
   logic                    meas_beat, use_x1, use_y1;
   logic [1:0]              corner_idx;
   logic signed [POS_W-1:0] meas_w, meas_h;

   assign out_load   = !rsp_valid_ff || rsp_chan.ready;
   assign emit       = job_valid_ff && out_load;
   assign meas_beat  = (beat_ff == BEAT_MEAS);
   assign last_beat  = meas_beat || (beat_ff == BEAT_LAST_CORNER && !job_ff.meas);
   assign done_now   = emit && last_beat;
   assign hand_ready = !job_valid_ff || done_now;
   assign take       = hand_valid && hand_ready;

   assign corner_idx = beat_ff[1:0];
   // corner walk: ccw goes x0y0 x1y0 x1y1 x0y1, cw goes x0y0 x0y1 x1y1 x1y0
   assign use_x1 = job_ff.cw ? corner_idx[1] : (corner_idx[1] ^ corner_idx[0]);
   assign use_y1 = job_ff.cw ? (corner_idx[1] ^ corner_idx[0]) : corner_idx[1];

   assign meas_w = (job_ff.lw > job_ff.wl) ? job_ff.lw : job_ff.wl;
   assign meas_h = sat_add(job_ff.nt, line_height);

   always_comb begin
      if (meas_beat) begin
         rsp_kind_in   = RES_MEAS;
         rsp_pos_x_in  = meas_w;
         rsp_pos_y_in  = meas_h;
         rsp_tex_s_in  = '0;
         rsp_tex_t_in  = '0;
         rsp_corner_in = '0;
         rsp_last_in   = 1'b1;
      end else begin
         rsp_kind_in   = RES_CORNER;
         rsp_pos_x_in  = use_x1 ? job_ff.x1 : job_ff.x0;
         rsp_pos_y_in  = use_y1 ? job_ff.y1 : job_ff.y0;
         rsp_tex_s_in  = tex_coord(use_x1 ? sb_ff : sa_ff, atlas_log2);
         // the top edge of the quad samples the bottom texel row
         rsp_tex_t_in  = tex_coord(use_y1 ? ta_ff : tb_ff, atlas_log2);
         rsp_corner_in = corner_idx;
         rsp_last_in   = (beat_ff == BEAT_LAST_CORNER) && !job_ff.fin;
      end
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      beat_in      = beat_ff;
      if (take) begin
         job_valid_in = 1'b1;
         beat_in      = job.quad ? BEAT_FIRST_CORNER : BEAT_MEAS;
      end else if (emit) begin
         if (last_beat) begin
            job_valid_in = 1'b0;
         end else if (beat_ff == BEAT_LAST_CORNER) begin
            beat_in = BEAT_MEAS;
         end else begin
            beat_in = beat_ff + 3'd1;
         end
      end
   end

   assign rsp_valid_in = out_load ? job_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         beat_ff      <= BEAT_FIRST_CORNER;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job;
         sa_ff  <= tex_sa;
         sb_ff  <= tex_sb;
         ta_ff  <= tex_ta;
         tb_ff  <= tex_tb;
      end
      if (emit) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_pos_x_ff  <= rsp_pos_x_in;
         rsp_pos_y_ff  <= rsp_pos_y_in;
         rsp_tex_s_ff  <= rsp_tex_s_in;
         rsp_tex_t_ff  <= rsp_tex_t_in;
         rsp_corner_ff <= rsp_corner_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.pos_x       = rsp_pos_x_ff;
   assign rsp_chan.pos_y       = rsp_pos_y_ff;
   assign rsp_chan.tex_s       = rsp_tex_s_ff;
   assign rsp_chan.tex_t       = rsp_tex_t_ff;
   assign rsp_chan.corner      = rsp_corner_ff;
   assign rsp_chan.last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> beat_ff <= BEAT_MEAS)
      else $error("sequencer beat out of range");

   a_meas_only_job: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_ff.quad |-> beat_ff == BEAT_MEAS)
      else $error("quadless job walking corners");

   a_meas_beat_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == RES_MEAS |-> rsp_corner_ff == 2'd0 && rsp_last_ff)
      else $error("measurement beat malformed");
`endif

endmodule

@@ src/text_glyph_quad_layout.sv @@
`timescale 1ns / 1ps
// Glyph quad layout engine. Load items write a glyph table entry; character
// items read their entry from a 256 x 40 synchronous RAM when accepted, move
// the pen in the following stage and hand the quad to an output sequencer.
// A printable glyph gives four corner beats (and a measurement beat when it
// ends a string); spaces and newlines that do not end a string give no beat.
// The single response port, one beat per cycle while the receiver is ready,
// sets the rate. A character passes the table read and pen stage registers,
// then the sequencer's job and response registers. The glyph table is not
// cleared at reset: an entry must be loaded before a character uses it.
module text_glyph_quad_layout import tgql_pkg::*; #(
   parameter int GLYPH_ENTRIES    = 256,
   parameter int ATLAS_COORD_BITS = 12,
   parameter int TEX_FRAC_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   tgql_req_if.sink              req_chan,
   tgql_rsp_if.source            rsp_chan
);

   localparam int IDX_W   = $clog2(GLYPH_ENTRIES);
   localparam int AX_W    = (ATLAS_COORD_BITS < ENTRY_COORD_W) ? ATLAS_COORD_BITS
                                                              : ENTRY_COORD_W;
   localparam int ENTRY_W = 2 * AX_W + 16;
   localparam int TEXEL_W = ((AX_W > 8) ? AX_W : 8) + 1;
   localparam logic [8:0] ENTRY_LIMIT = 9'(GLYPH_ENTRIES);

   // configuration
   logic [7:0] min_code_ff, max_code_ff, line_height_ff;
   logic [3:0] atlas_log2_ff;
   logic       winding_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_code_ff    <= RST_MIN_CODE;
         max_code_ff    <= RST_MAX_CODE;
         line_height_ff <= RST_LINE_HEIGHT;
         atlas_log2_ff  <= RST_ATLAS_LOG2;
         winding_ff     <= RST_WINDING;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_CODE:    min_code_ff    <= csr_wdata;
            CSR_MAX_CODE:    max_code_ff    <= csr_wdata;
            CSR_LINE_HEIGHT: line_height_ff <= csr_wdata;
            CSR_ATLAS_LOG2:  atlas_log2_ff  <= csr_wdata[3:0];
            CSR_WINDING:     winding_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // accept stage: code mapping and table access
   logic               req_accept, char_in_range, space_in_range, lookup_ok, is_space;
   logic               wr_ok;
   logic [7:0]         mapped_code, glyph_off;
   logic [ENTRY_W-1:0] wr_word;
   logic [ENTRY_W-1:0] glyph_mem [GLYPH_ENTRIES];
   logic [ENTRY_W-1:0] rd_word_ff;

   assign req_accept     = req_chan.valid && req_chan.ready;
   assign char_in_range  = (req_chan.char_code >= min_code_ff) &&
                           (req_chan.char_code <= max_code_ff);
   assign space_in_range = (CODE_SPACE >= min_code_ff) && (CODE_SPACE <= max_code_ff);
   assign mapped_code    = char_in_range ? req_chan.char_code : CODE_SPACE;
   assign glyph_off      = mapped_code - min_code_ff;
   assign lookup_ok      = (char_in_range || space_in_range) &&
                           ({1'b0, glyph_off} < ENTRY_LIMIT);
   assign is_space       = !char_in_range || (req_chan.char_code == CODE_SPACE);
   assign wr_ok          = {1'b0, req_chan.entry_index} < ENTRY_LIMIT;
   assign wr_word        = {req_chan.entry_atlas_x[AX_W-1:0], req_chan.entry_atlas_y[AX_W-1:0],
                            req_chan.entry_cell_size, req_chan.entry_advance};

   always_ff @(posedge clock) begin
      if (req_accept && req_chan.kind == KIND_LOAD && wr_ok) begin
         glyph_mem[req_chan.entry_index[IDX_W-1:0]] <= wr_word;
      end
      if (req_accept && req_chan.kind == KIND_CHAR) begin
         rd_word_ff <= glyph_mem[glyph_off[IDX_W-1:0]];
      end
   end

   // pen stage
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_newline_ff, s1_space_ff, s1_ok_ff, s1_first_ff, s1_last_ff;
   logic signed [15:0] s1_start_x_ff, s1_start_y_ff;
   logic               s1_go, needs_job, hand_valid, hand_ready;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = (req_chan.kind == KIND_CHAR);
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign req_chan.ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_chan.kind == KIND_CHAR) begin
         s1_newline_ff <= (req_chan.char_code == CODE_NEWLINE);
         s1_space_ff   <= is_space;
         s1_ok_ff      <= lookup_ok;
         s1_first_ff   <= req_chan.first_of_string;
         s1_last_ff    <= req_chan.last_of_string;
         s1_start_x_ff <= req_chan.start_x;
         s1_start_y_ff <= req_chan.start_y;
      end
   end

   logic [AX_W-1:0]         g_ax, g_ay;
   logic [7:0]              g_size, g_adv;
   logic signed [POS_W-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic signed [POS_W-1:0] lw_ff, lw_in, wl_ff, wl_in, nt_ff, nt_in;
   logic signed [POS_W-1:0] px_cur, py_cur, lw_cur, wl_cur, nt_cur;
   tgql_job_type            job;
   logic [TEXEL_W-1:0]      tex_sa, tex_sb, tex_ta, tex_tb;

   // off-table entries, or code and space both out of range, read as zero
   assign g_ax   = s1_ok_ff ? rd_word_ff[ENTRY_W-1 -: AX_W]      : '0;
   assign g_ay   = s1_ok_ff ? rd_word_ff[ENTRY_W-AX_W-1 -: AX_W] : '0;
   assign g_size = s1_ok_ff ? rd_word_ff[15:8]                   : '0;
   assign g_adv  = s1_ok_ff ? rd_word_ff[7:0]                    : '0;

   assign px_cur = s1_first_ff ? {{(POS_W-16){s1_start_x_ff[15]}}, s1_start_x_ff} : pen_x_ff;
   assign py_cur = s1_first_ff ? {{(POS_W-16){s1_start_y_ff[15]}}, s1_start_y_ff} : pen_y_ff;
   assign lw_cur = s1_first_ff ? '0 : lw_ff;
   assign wl_cur = s1_first_ff ? '0 : wl_ff;
   assign nt_cur = s1_first_ff ? '0 : nt_ff;

   always_comb begin
      if (s1_newline_ff) begin
         wl_in    = (lw_cur > wl_cur) ? lw_cur : wl_cur;
         lw_in    = '0;
         pen_x_in = '0;
         pen_y_in = sat_add(py_cur, line_height_ff);
         nt_in    = sat_add(nt_cur, line_height_ff);
      end else begin
         wl_in    = wl_cur;
         lw_in    = sat_add(lw_cur, g_adv);
         pen_x_in = sat_add(px_cur, g_adv);
         pen_y_in = py_cur;
         nt_in    = nt_cur;
      end
   end

   always_comb begin
      job.quad = !s1_newline_ff && !s1_space_ff;
      job.meas = s1_last_ff;
      job.fin  = s1_last_ff;
      job.cw   = winding_ff;
      job.x0   = px_cur;
      job.y0   = py_cur;
      job.x1   = sat_add(px_cur, g_size);
      job.y1   = sat_add(py_cur, g_size);
      job.lw   = lw_in;
      job.wl   = wl_in;
      job.nt   = nt_in;
   end

   assign tex_sa = TEXEL_W'(g_ax);
   assign tex_sb = TEXEL_W'(g_ax) + TEXEL_W'(g_size);
   assign tex_ta = TEXEL_W'(g_ay);
   assign tex_tb = TEXEL_W'(g_ay) + TEXEL_W'(g_size);

   assign needs_job  = job.quad || s1_last_ff;
   assign hand_valid = s1_valid_ff && needs_job;
   assign s1_go      = s1_valid_ff && (!needs_job || hand_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         lw_ff    <= '0;
         wl_ff    <= '0;
         nt_ff    <= '0;
      end else if (s1_go) begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         lw_ff    <= lw_in;
         wl_ff    <= wl_in;
         nt_ff    <= nt_in;
      end
   end

   tgql_emit #(
      .TEXEL_W       (TEXEL_W),
      .TEX_FRAC_BITS (TEX_FRAC_BITS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .hand_valid  (hand_valid),
      .hand_ready  (hand_ready),
      .job         (job),
      .tex_sa      (tex_sa),
      .tex_sb      (tex_sb),
      .tex_ta      (tex_ta),
      .tex_tb      (tex_tb),
      .line_height (line_height_ff),
      .atlas_log2  (atlas_log2_ff),
      .rsp_chan    (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   a_char_enters_pen: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.kind == KIND_CHAR |=> s1_valid_ff)
      else $error("accepted character missing from pen stage");

   a_measure_nonneg: assert property (@(posedge clock) disable iff (reset)
      !(lw_ff[POS_W-1] || wl_ff[POS_W-1] || nt_ff[POS_W-1]))
      else $error("measurement register went negative");

   a_newline_home: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_newline_ff |=> pen_x_ff == '0 && lw_ff == '0)
      else $error("newline did not return the pen");
`endif

endmodule
